// ===== src/rotation_matrix_to_quaternion_unit_macros.svh =====
// assertion macros for the rotation matrix to quaternion rtl
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define RMQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define RMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rmq_pkg.sv =====
package rmq_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = DATA_WIDTH - 2;
  // trace sums of three elements
  localparam int TRACE_W    = DATA_WIDTH + 2;
  // off-diagonal sum or difference, and its magnitude
  localparam int DIFF_W     = DATA_WIDTH + 1;
  // square root: one result bit per step
  localparam int SQ_STEPS   = DATA_WIDTH - 1;
  localparam int ROOT_W     = SQ_STEPS;
  localparam int RAD_W      = 2 * SQ_STEPS;
  localparam int SQ_REM_W   = ROOT_W + 4;
  // division: divisor is four times the root
  localparam int DEN_W      = ROOT_W + 2;
  localparam int DIV_P_W    = DEN_W + 1;
  localparam int DIVIDEND_W = DATA_WIDTH + FRAC_BITS + 1;
  // smallest divisor is 2^(FRAC_BITS/2+1), so the top quotient bits are zero
  localparam int QUO_W      = DIVIDEND_W - (FRAC_BITS / 2 + 1);

  localparam logic signed [DATA_WIDTH-1:0] FIX_ONE = {2'b01, {FRAC_BITS{1'b0}}};
  localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    COMP_W,
    COMP_X,
    COMP_Y,
    COMP_Z
  } comp_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] m_r0_c0;
    logic signed [DATA_WIDTH-1:0] m_r0_c1;
    logic signed [DATA_WIDTH-1:0] m_r0_c2;
    logic signed [DATA_WIDTH-1:0] m_r1_c0;
    logic signed [DATA_WIDTH-1:0] m_r1_c1;
    logic signed [DATA_WIDTH-1:0] m_r1_c2;
    logic signed [DATA_WIDTH-1:0] m_r2_c0;
    logic signed [DATA_WIDTH-1:0] m_r2_c1;
    logic signed [DATA_WIDTH-1:0] m_r2_c2;
  } in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] quat_w;
    logic signed [DATA_WIDTH-1:0] quat_x;
    logic signed [DATA_WIDTH-1:0] quat_y;
    logic signed [DATA_WIDTH-1:0] quat_z;
    logic [1:0]                   largest_component;
    logic                         degenerate;
  } out_t;

  // travels beside the square root
  typedef struct packed {
    logic [2:0][DIFF_W-1:0] mag;
    logic [2:0]             neg;
    comp_t                  big;
    logic                   degen;
  } sq_side_t;

  // travels beside the division
  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic [2:0]        neg;
    comp_t             big;
    logic              degen;
  } dv_side_t;

endpackage

// ===== src/rmq_isqrt.sv =====
module rmq_isqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [rmq_pkg::RAD_W-1:0]    in_rad,
  input  rmq_pkg::sq_side_t            in_side,
  output logic                         out_valid,
  output logic [rmq_pkg::ROOT_W-1:0]   out_root,
  output rmq_pkg::sq_side_t            out_side
);

  logic                           vld  [rmq_pkg::SQ_STEPS+1];
  logic [rmq_pkg::RAD_W-1:0]      rad  [rmq_pkg::SQ_STEPS+1];
  logic [rmq_pkg::SQ_REM_W-1:0]   rem  [rmq_pkg::SQ_STEPS+1];
  logic [rmq_pkg::ROOT_W-1:0]     root [rmq_pkg::SQ_STEPS+1];
  rmq_pkg::sq_side_t              side [rmq_pkg::SQ_STEPS+1];

  assign vld[0]  = in_valid;
  assign rad[0]  = in_rad;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign side[0] = in_side;

  // one root bit per stage, two radicand bits brought down each time
  for (genvar i = 0; i < rmq_pkg::SQ_STEPS; i++) begin : g_step
    logic [rmq_pkg::SQ_REM_W-1:0] rem_sh;
    logic [rmq_pkg::SQ_REM_W-1:0] trial;
    logic                         ge;

    assign rem_sh = {rem[i][rmq_pkg::SQ_REM_W-3:0], rad[i][rmq_pkg::RAD_W-1 -: 2]};
    assign trial  = rmq_pkg::SQ_REM_W'({root[i], 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[i+1]  <= rad[i] << 2;
        rem[i+1]  <= ge ? rem_sh - trial : rem_sh;
        root[i+1] <= {root[i][rmq_pkg::ROOT_W-2:0], ge};
        side[i+1] <= side[i];
      end
    end
  end

  assign out_valid = vld[rmq_pkg::SQ_STEPS];
  assign out_root  = root[rmq_pkg::SQ_STEPS];
  assign out_side  = side[rmq_pkg::SQ_STEPS];

endmodule

// ===== src/rmq_divide.sv =====
module rmq_divide (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [rmq_pkg::ROOT_W-1:0]          in_root,
  input  rmq_pkg::sq_side_t                   in_side,
  output logic                                out_valid,
  output logic [2:0][rmq_pkg::QUO_W-1:0]      out_quo,
  output rmq_pkg::dv_side_t                   out_side
);

  logic                                  vld  [rmq_pkg::QUO_W+1];
  logic [2:0][rmq_pkg::DIV_P_W-1:0]      p    [rmq_pkg::QUO_W+1];
  logic [2:0][rmq_pkg::QUO_W-1:0]        xs   [rmq_pkg::QUO_W+1];
  logic [rmq_pkg::DEN_W-1:0]             den  [rmq_pkg::QUO_W+1];
  rmq_pkg::dv_side_t                     side [rmq_pkg::QUO_W+1];

  logic [2:0][rmq_pkg::DIVIDEND_W-1:0]   x;

  // dividend is mag * 2^F plus half the divisor for round to nearest
  for (genvar k = 0; k < 3; k++) begin : g_prep
    assign x[k] = (rmq_pkg::DIVIDEND_W'(in_side.mag[k]) << rmq_pkg::FRAC_BITS)
                + rmq_pkg::DIVIDEND_W'({in_root, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p[0][k]  <= rmq_pkg::DIV_P_W'(x[k][rmq_pkg::DIVIDEND_W-1:rmq_pkg::QUO_W]);
        xs[0][k] <= x[k][rmq_pkg::QUO_W-1:0];
      end
      den[0]        <= {in_root, 2'b00};
      side[0].root  <= in_root;
      side[0].neg   <= in_side.neg;
      side[0].big   <= in_side.big;
      side[0].degen <= in_side.degen;
    end
  end

  // restoring division, one quotient bit per stage; quotient bits
  // shift into the low end of the dividend word
  for (genvar i = 0; i < rmq_pkg::QUO_W; i++) begin : g_step
    logic [2:0][rmq_pkg::DIV_P_W-1:0] p_nx;
    logic [2:0][rmq_pkg::QUO_W-1:0]   xs_nx;

    for (genvar k = 0; k < 3; k++) begin : g_lane
      logic [rmq_pkg::DIV_P_W-1:0] p_sh;
      logic                        ge;

      assign p_sh      = {p[i][k][rmq_pkg::DEN_W-1:0], xs[i][k][rmq_pkg::QUO_W-1]};
      assign ge        = p_sh >= rmq_pkg::DIV_P_W'(den[i]);
      assign p_nx[k]   = ge ? p_sh - rmq_pkg::DIV_P_W'(den[i]) : p_sh;
      assign xs_nx[k]  = {xs[i][k][rmq_pkg::QUO_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        p[i+1]    <= p_nx;
        xs[i+1]   <= xs_nx;
        den[i+1]  <= den[i];
        side[i+1] <= side[i];
      end
    end
  end

  assign out_valid = vld[rmq_pkg::QUO_W];
  assign out_quo   = xs[rmq_pkg::QUO_W];
  assign out_side  = side[rmq_pkg::QUO_W];

endmodule

// ===== src/rotation_matrix_to_quaternion_unit.sv =====
// Rotation matrix to unit quaternion, signed Q2.14 in and out. One transfer
// of nine matrix elements gives one transfer of w, x, y, z, the index of the
// largest trace combination (earlier of w, x, y, z wins a tie) and a
// degenerate flag that replaces the answer with the identity quaternion when
// the radicand is not positive. The block takes a new transfer every cycle
// unless the output is stalled; each one passes through an input register,
// one stage for traces, pick and radicand, 15 square root stages (one root bit
// each), one dividend setup stage, 23 restoring division stages (one
// quotient bit each, three lanes side by side) and the output register.
// A stall on the output freezes the whole pipe and shows as a stall on the
// input in the same cycle; nothing is dropped or repeated.
`include "rotation_matrix_to_quaternion_unit_macros.svh"

module rotation_matrix_to_quaternion_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  rmq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output rmq_pkg::out_t out_data
);

  // global advance: the pipe moves unless a finished result is held
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // input register
  logic         a_valid;
  rmq_pkg::in_t a_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_data <= in_data;
    end
  end

  // trace combinations and pick of the largest
  logic signed [rmq_pkg::TRACE_W-1:0] m00, m11, m22;
  logic signed [rmq_pkg::TRACE_W-1:0] tw, tx, ty, tz, tmax, rad_s;
  rmq_pkg::comp_t                     pick;
  logic                               degen;
  logic [rmq_pkg::RAD_W-1:0]          rad;

  assign m00 = rmq_pkg::TRACE_W'(a_data.m_r0_c0);
  assign m11 = rmq_pkg::TRACE_W'(a_data.m_r1_c1);
  assign m22 = rmq_pkg::TRACE_W'(a_data.m_r2_c2);
  assign tw  = m00 + m11 + m22;
  assign tx  = m00 - m11 - m22;
  assign ty  = m11 - m00 - m22;
  assign tz  = m22 - m00 - m11;

  // strict greater-than so the earlier component wins a tie
  always_comb begin
    pick = rmq_pkg::COMP_W;
    tmax = tw;
    if (tx > tmax) begin
      pick = rmq_pkg::COMP_X;
      tmax = tx;
    end
    if (ty > tmax) begin
      pick = rmq_pkg::COMP_Y;
      tmax = ty;
    end
    if (tz > tmax) begin
      pick = rmq_pkg::COMP_Z;
      tmax = tz;
    end
  end

  assign rad_s = tmax + rmq_pkg::TRACE_W'(rmq_pkg::FIX_ONE);
  assign degen = rad_s[rmq_pkg::TRACE_W-1] || (rad_s == '0);
  // sqrt(r)/2 in Q2.F is sqrt(r * 2^(F-2)); a degenerate item gets a zero radicand
  assign rad   = degen ? '0
               : (rmq_pkg::RAD_W'(rad_s[rmq_pkg::TRACE_W-2:0]) << (rmq_pkg::FRAC_BITS - 2));

  // off-diagonal sums and differences
  logic signed [rmq_pkg::DIFF_W-1:0] d12m, d20m, d01m, d01p, d20p, d12p;
  logic signed [rmq_pkg::DIFF_W-1:0] lane_d [3];
  rmq_pkg::sq_side_t                 b_side_nx;

  assign d12m = rmq_pkg::DIFF_W'(a_data.m_r1_c2) - rmq_pkg::DIFF_W'(a_data.m_r2_c1);
  assign d20m = rmq_pkg::DIFF_W'(a_data.m_r2_c0) - rmq_pkg::DIFF_W'(a_data.m_r0_c2);
  assign d01m = rmq_pkg::DIFF_W'(a_data.m_r0_c1) - rmq_pkg::DIFF_W'(a_data.m_r1_c0);
  assign d01p = rmq_pkg::DIFF_W'(a_data.m_r0_c1) + rmq_pkg::DIFF_W'(a_data.m_r1_c0);
  assign d20p = rmq_pkg::DIFF_W'(a_data.m_r2_c0) + rmq_pkg::DIFF_W'(a_data.m_r0_c2);
  assign d12p = rmq_pkg::DIFF_W'(a_data.m_r1_c2) + rmq_pkg::DIFF_W'(a_data.m_r2_c1);

  // lanes carry the three other components in ascending order
  always_comb begin
    unique case (pick)
      rmq_pkg::COMP_W: begin
        lane_d[0] = d12m;
        lane_d[1] = d20m;
        lane_d[2] = d01m;
      end
      rmq_pkg::COMP_X: begin
        lane_d[0] = d12m;
        lane_d[1] = d01p;
        lane_d[2] = d20p;
      end
      rmq_pkg::COMP_Y: begin
        lane_d[0] = d20m;
        lane_d[1] = d01p;
        lane_d[2] = d12p;
      end
      default: begin
        lane_d[0] = d01m;
        lane_d[1] = d20p;
        lane_d[2] = d12p;
      end
    endcase
  end

  // sign and magnitude per lane
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      b_side_nx.neg[k] = lane_d[k][rmq_pkg::DIFF_W-1];
      b_side_nx.mag[k] = lane_d[k][rmq_pkg::DIFF_W-1] ? -lane_d[k] : lane_d[k];
    end
    b_side_nx.big   = pick;
    b_side_nx.degen = degen;
  end

  // trace stage register
  logic                      b_valid;
  logic [rmq_pkg::RAD_W-1:0] b_rad;
  rmq_pkg::sq_side_t         b_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_rad  <= rad;
      b_side <= b_side_nx;
    end
  end

  // square root of the radicand
  logic                       sq_valid;
  logic [rmq_pkg::ROOT_W-1:0] sq_root;
  rmq_pkg::sq_side_t          sq_side;

  rmq_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b_valid),
    .in_rad    (b_rad),
    .in_side   (b_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // d * 2^F / (4 * root) on three lanes
  logic                              dv_valid;
  logic [2:0][rmq_pkg::QUO_W-1:0]    dv_quo;
  rmq_pkg::dv_side_t                 dv_side;

  rmq_divide u_divide (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .in_root   (sq_root),
    .in_side   (sq_side),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_side  (dv_side)
  );

  // apply sign and saturate to the output width
  function automatic logic signed [rmq_pkg::DATA_WIDTH-1:0] sat_signed(
    input logic [rmq_pkg::QUO_W-1:0] q,
    input logic                      neg
  );
    logic over;
    logic signed [rmq_pkg::DATA_WIDTH-1:0] low;
    over = q[rmq_pkg::QUO_W-1:rmq_pkg::DATA_WIDTH-1] != '0;
    low  = q[rmq_pkg::DATA_WIDTH-1:0];
    if (neg) begin
      sat_signed = over ? rmq_pkg::SAT_MIN : -low;
    end else begin
      sat_signed = over ? rmq_pkg::SAT_MAX : low;
    end
  endfunction

  logic signed [rmq_pkg::DATA_WIDTH-1:0] lane_q [3];
  logic signed [rmq_pkg::DATA_WIDTH-1:0] root_q;
  rmq_pkg::out_t                         out_nx;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lane_q[k] = sat_signed(dv_quo[k], dv_side.neg[k]);
    end
  end

  assign root_q = rmq_pkg::DATA_WIDTH'(dv_side.root);

  // put the root at the picked place and the lanes around it
  always_comb begin
    unique case (dv_side.big)
      rmq_pkg::COMP_W: begin
        out_nx.quat_w = root_q;
        out_nx.quat_x = lane_q[0];
        out_nx.quat_y = lane_q[1];
        out_nx.quat_z = lane_q[2];
      end
      rmq_pkg::COMP_X: begin
        out_nx.quat_w = lane_q[0];
        out_nx.quat_x = root_q;
        out_nx.quat_y = lane_q[1];
        out_nx.quat_z = lane_q[2];
      end
      rmq_pkg::COMP_Y: begin
        out_nx.quat_w = lane_q[0];
        out_nx.quat_x = lane_q[1];
        out_nx.quat_y = root_q;
        out_nx.quat_z = lane_q[2];
      end
      default: begin
        out_nx.quat_w = lane_q[0];
        out_nx.quat_x = lane_q[1];
        out_nx.quat_y = lane_q[2];
        out_nx.quat_z = root_q;
      end
    endcase
    // degenerate: identity quaternion
    if (dv_side.degen) begin
      out_nx.quat_w = rmq_pkg::FIX_ONE;
      out_nx.quat_x = '0;
      out_nx.quat_y = '0;
      out_nx.quat_z = '0;
    end
    out_nx.largest_component = dv_side.big;
    out_nx.degenerate        = dv_side.degen;
  end

  // output register, held while the consumer stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_nx;
    end
  end

  `RMQ_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, a_valid, "accepted transfer not in input stage")
  `RMQ_ASSERT_IMPLY(a_degen_identity, out_valid && out_data.degenerate, (out_data.quat_w == rmq_pkg::FIX_ONE) && (out_data.quat_x == '0) && (out_data.quat_y == '0) && (out_data.quat_z == '0), "degenerate result is not identity")
  `RMQ_ASSERT_IMPLY(a_largest_nonneg, out_valid && !out_data.degenerate, (out_data.largest_component == rmq_pkg::COMP_W && !out_data.quat_w[rmq_pkg::DATA_WIDTH-1]) || (out_data.largest_component == rmq_pkg::COMP_X && !out_data.quat_x[rmq_pkg::DATA_WIDTH-1]) || (out_data.largest_component == rmq_pkg::COMP_Y && !out_data.quat_y[rmq_pkg::DATA_WIDTH-1]) || (out_data.largest_component == rmq_pkg::COMP_Z && !out_data.quat_z[rmq_pkg::DATA_WIDTH-1]), "largest component is negative")

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import rmq_pkg::*;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  rotation_matrix_to_quaternion_unit dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  localparam int NUM_RANDOM  = 1800;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PIPE_DEPTH  = 42;

  // directed row: matrix, plus a typed-in answer where it is obvious
  typedef struct {
    in_t  mat;
    logic fixed;
    out_t ans;
  } row_t;

  out_t quat_queue[$];
  int   failures;
  int   cycles;
  row_t rows[$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // isqrt of a non-negative value, bit by bit
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // d * 2^F / (4 root), nearest, ties away from zero
  function automatic longint scaled_quot(longint d, longint unsigned root);
    longint unsigned mag;
    longint unsigned den;
    longint unsigned q;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    den = 4 * root;
    q = ((mag << FRAC_BITS) + (den >> 1)) / den;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [DATA_WIDTH-1:0] clip(longint v);
    if (v > longint'(SAT_MAX)) return SAT_MAX;
    if (v < longint'(SAT_MIN)) return SAT_MIN;
    return v[DATA_WIDTH-1:0];
  endfunction

  function automatic out_t quat_of_matrix(in_t a);
    longint m[9];
    longint tr[4];
    longint q[4];
    longint rad;
    longint unsigned root;
    longint d12m, d20m, d01m, d01p, d20p, d12p;
    int big;
    out_t o;
    m[0] = a.m_r0_c0; m[1] = a.m_r0_c1; m[2] = a.m_r0_c2;
    m[3] = a.m_r1_c0; m[4] = a.m_r1_c1; m[5] = a.m_r1_c2;
    m[6] = a.m_r2_c0; m[7] = a.m_r2_c1; m[8] = a.m_r2_c2;
    tr[0] = m[0] + m[4] + m[8];
    tr[1] = m[0] - m[4] - m[8];
    tr[2] = m[4] - m[0] - m[8];
    tr[3] = m[8] - m[0] - m[4];
    big = 0;
    for (int i = 1; i < 4; i++) if (tr[i] > tr[big]) big = i;
    rad = tr[big] + longint'(FIX_ONE);
    if (rad <= 0) begin
      q[0] = FIX_ONE; q[1] = 0; q[2] = 0; q[3] = 0;
    end else begin
      root = int_sqrt(longint'(rad) << (FRAC_BITS - 2));
      d12m = m[5] - m[7]; d20m = m[6] - m[2]; d01m = m[1] - m[3];
      d01p = m[1] + m[3]; d20p = m[6] + m[2]; d12p = m[5] + m[7];
      case (comp_t'(big))
        COMP_W: begin
          q[1] = scaled_quot(d12m, root); q[2] = scaled_quot(d20m, root);
          q[3] = scaled_quot(d01m, root);
        end
        COMP_X: begin
          q[0] = scaled_quot(d12m, root); q[2] = scaled_quot(d01p, root);
          q[3] = scaled_quot(d20p, root);
        end
        COMP_Y: begin
          q[0] = scaled_quot(d20m, root); q[1] = scaled_quot(d01p, root);
          q[3] = scaled_quot(d12p, root);
        end
        default: begin
          q[0] = scaled_quot(d01m, root); q[1] = scaled_quot(d20p, root);
          q[2] = scaled_quot(d12p, root);
        end
      endcase
      q[big] = longint'(root);
    end
    o.quat_w = clip(q[0]);
    o.quat_x = clip(q[1]);
    o.quat_y = clip(q[2]);
    o.quat_z = clip(q[3]);
    o.largest_component = big[1:0];
    o.degenerate = (rad <= 0);
    return o;
  endfunction

  function automatic in_t diag_matrix(logic [DATA_WIDTH-1:0] a, logic [DATA_WIDTH-1:0] b,
                                      logic [DATA_WIDTH-1:0] c);
    in_t x;
    x = '0;
    x.m_r0_c0 = a;
    x.m_r1_c1 = b;
    x.m_r2_c2 = c;
    return x;
  endfunction

  function automatic in_t rand_matrix();
    logic [159:0] bits;
    in_t x;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
    x = bits[$bits(in_t)-1:0];
    return x;
  endfunction

  // well-formed-ish: diagonal and four off-diagonal values in [-1, 1], r1_c2 and r2_c1 random
  function automatic in_t near_rotation();
    in_t x;
    x = rand_matrix();
    x.m_r0_c0 = DATA_WIDTH'($signed($urandom_range(0, 32768)) - 16384);
    x.m_r1_c1 = DATA_WIDTH'($signed($urandom_range(0, 32768)) - 16384);
    x.m_r2_c2 = DATA_WIDTH'($signed($urandom_range(0, 32768)) - 16384);
    x.m_r0_c1 = DATA_WIDTH'($signed($urandom_range(0, 32768)) - 16384);
    x.m_r1_c0 = DATA_WIDTH'($signed($urandom_range(0, 32768)) - 16384);
    x.m_r0_c2 = DATA_WIDTH'($signed($urandom_range(0, 32768)) - 16384);
    x.m_r2_c0 = DATA_WIDTH'($signed($urandom_range(0, 32768)) - 16384);
    return x;
  endfunction

  function automatic void add_row(in_t mat, logic fixed, out_t ans);
    row_t r;
    r.mat = mat;
    r.fixed = fixed;
    r.ans = ans;
    rows.push_back(r);
  endfunction

  // one transfer on the input side, holding until accepted
  task automatic send_matrix(in_t mat, out_t ans);
    in_valid <= 1'b1;
    in_data  <= mat;
    quat_queue.push_back(ans);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic gap(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // receiver stalls in its own pattern: long open stretches, then busy spells
  initial begin
    int phase;
    out_stall = 1'b0;
    phase = 0;
    forever begin
      @(posedge clk);
      phase++;
      if ((phase / 300) % 3 == 0) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 99) < 35);
    end
  end

  // compare each output transfer with the oldest expectation
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (quat_queue.size() == 0) begin
        $display("%0t: unexpected transfer, got %h", $time, out_data);
        failures++;
      end else begin
        want = quat_queue.pop_front();
        if (out_data.quat_w !== want.quat_w) begin
          $display("%0t: quat_w exp %h got %h", $time, want.quat_w, out_data.quat_w);
          failures++;
        end
        if (out_data.quat_x !== want.quat_x) begin
          $display("%0t: quat_x exp %h got %h", $time, want.quat_x, out_data.quat_x);
          failures++;
        end
        if (out_data.quat_y !== want.quat_y) begin
          $display("%0t: quat_y exp %h got %h", $time, want.quat_y, out_data.quat_y);
          failures++;
        end
        if (out_data.quat_z !== want.quat_z) begin
          $display("%0t: quat_z exp %h got %h", $time, want.quat_z, out_data.quat_z);
          failures++;
        end
        if (out_data.largest_component !== want.largest_component) begin
          $display("%0t: largest exp %0d got %0d", $time, want.largest_component,
                   out_data.largest_component);
          failures++;
        end
        if (out_data.degenerate !== want.degenerate) begin
          $display("%0t: degenerate exp %b got %b", $time, want.degenerate,
                   out_data.degenerate);
          failures++;
        end
      end
    end
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    out_t ident;
    out_t want;
    int left;
    int burst;
    in_t mat;
    failures = 0;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // identity matrix: plainly w = 1, nothing else
    ident = '0;
    ident.quat_w = FIX_ONE;
    ident.largest_component = COMP_W;
    add_row(diag_matrix(FIX_ONE, FIX_ONE, FIX_ONE), 1'b1, ident);
    // all zero: radicand one, w = sqrt(1)/2
    want = '0;
    want.quat_w = FIX_ONE >>> 1;
    add_row('0, 1'b1, want);
    // most negative diagonal: x, y, z traces tie and x wins
    add_row(diag_matrix(SAT_MIN, SAT_MIN, SAT_MIN), 1'b0, ident);
    // half turns about x, y, z pick each component in turn
    add_row(diag_matrix(FIX_ONE, -FIX_ONE, -FIX_ONE), 1'b0, ident);
    add_row(diag_matrix(-FIX_ONE, FIX_ONE, -FIX_ONE), 1'b0, ident);
    add_row(diag_matrix(-FIX_ONE, -FIX_ONE, FIX_ONE), 1'b0, ident);
    // ties: equal traces go to the earlier component
    add_row(diag_matrix('0, '0, -FIX_ONE), 1'b0, ident);
    add_row(diag_matrix(-FIX_ONE, '0, '0), 1'b0, ident);
    // extremes everywhere, saturating outputs
    add_row(in_t'({9{SAT_MAX}}), 1'b0, ident);
    add_row(in_t'({9{SAT_MIN}}), 1'b0, ident);
    mat = diag_matrix(SAT_MAX, SAT_MIN, SAT_MIN);
    mat.m_r0_c1 = SAT_MAX; mat.m_r1_c0 = SAT_MAX;
    add_row(mat, 1'b0, ident);
    mat = diag_matrix(-16'sd6000, -16'sd6000, -16'sd6000);
    mat.m_r1_c2 = SAT_MAX; mat.m_r2_c1 = SAT_MIN;
    add_row(mat, 1'b0, ident);
    // diagonals with negative entries, where a trace other than w's is largest
    add_row(diag_matrix(-FIX_ONE, '0, '0 + 16'sd0), 1'b0, ident);
    add_row(diag_matrix(-16'sd5461, -16'sd5461, -16'sd5462), 1'b0, ident);
    add_row(diag_matrix(-16'sd5461, -16'sd5461, -16'sd5461), 1'b0, ident);

    foreach (rows[i])
      send_matrix(rows[i].mat, rows[i].fixed ? rows[i].ans : quat_of_matrix(rows[i].mat));
    gap(1);

    left = NUM_RANDOM;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      if (burst > left) burst = left;
      repeat (burst) begin
        if ($urandom_range(0, 3) == 0) mat = rand_matrix();
        else mat = near_rotation();
        send_matrix(mat, quat_of_matrix(mat));
      end
      left -= burst;
      if (left < NUM_RANDOM / 2 && left + burst >= NUM_RANDOM / 2) begin
        // hold off until the pipe has drained
        in_valid <= 1'b0;
        while (quat_queue.size() != 0) @(posedge clk);
      end else if ($urandom_range(0, 2) != 0) begin
        gap($urandom_range(1, 12));
      end
    end
    in_valid <= 1'b0;

    while (quat_queue.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (failures == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
